>>> design/cpf_pkg.sv
package cpf_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int HDR_BYTES   = 7;
  localparam logic [15:0] CRC_SEED = 16'hFFFF;

  localparam logic [1:0] REG_START_MARKER = 2'd0;
  localparam logic [1:0] REG_SYSTEM_ID    = 2'd1;
  localparam logic [1:0] REG_COMPONENT_ID = 2'd2;

  typedef enum logic {
    OP_START = 1'b0,
    OP_DATA  = 1'b1
  } op_t;

  // one classified item on its way from front to back
  typedef struct packed {
    op_t         op;
    logic        last;          // frame closes after this item
    logic [15:0] frame_length;
    logic [7:0]  heartbeat;
    logic [7:0]  msg_id;
    logic [7:0]  payload_byte;
  } cmd_t;

  typedef struct packed {
    logic [7:0] start_marker;
    logic [7:0] system_id;
    logic [7:0] component_id;
  } cfg_regs_t;

  typedef enum logic [1:0] {
    ST_CMD,
    ST_HDR,
    ST_CRC_LO,
    ST_CRC_HI
  } back_state_t;

  // CRC-16/MCRF4XX, one byte, reflected 0x1021
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0] t;
    t = b ^ crc[7:0];
    t = t ^ {t[3:0], 4'b0000};
    return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
  endfunction

endpackage

>>> design/cpf_front.sv
module cpf_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           kind,
  input  logic [15:0]    frame_length,
  input  logic [7:0]     heartbeat,
  input  logic [7:0]     msg_id,
  input  logic [7:0]     payload_byte,
  input  logic           q_full,
  output logic           q_push,
  output cpf_pkg::cmd_t  q_cmd
);

  logic        in_frame;
  logic [15:0] bytes_left;
  logic        accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;

  // payload outside a frame is swallowed here and never reaches the queue
  assign q_push = accept && (kind == cpf_pkg::OP_START || in_frame);

  always_comb begin
    q_cmd.op           = (kind == cpf_pkg::OP_START) ? cpf_pkg::OP_START : cpf_pkg::OP_DATA;
    q_cmd.last         = (kind == cpf_pkg::OP_START) ? (frame_length == 16'd0)
                                                     : (bytes_left == 16'd1);
    q_cmd.frame_length = frame_length;
    q_cmd.heartbeat    = heartbeat;
    q_cmd.msg_id       = msg_id;
    q_cmd.payload_byte = payload_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame   <= 1'b0;
      bytes_left <= 16'd0;
    end else if (q_push) begin
      if (kind == cpf_pkg::OP_START) begin
        in_frame   <= (frame_length != 16'd0);
        bytes_left <= frame_length;
      end else begin
        in_frame   <= (bytes_left != 16'd1);
        bytes_left <= bytes_left - 16'd1;
      end
    end
  end

endmodule

>>> design/cpf_queue.sv
module cpf_queue #(
  parameter int DEPTH = cpf_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cpf_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output cpf_pkg::cmd_t pop_cmd,
  output logic          empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cpf_pkg::cmd_t mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign pop_cmd = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> design/cpf_back.sv
module cpf_back (
  input  logic               clk,
  input  logic               rst,
  input  cpf_pkg::cfg_regs_t cfg,
  input  logic               q_empty,
  input  cpf_pkg::cmd_t      q_cmd,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_byte,
  output logic               frame_end
);

  cpf_pkg::back_state_t state, state_next;
  cpf_pkg::cmd_t        cur, cur_next;
  logic [2:0]           step, step_next;
  logic [15:0]          crc, crc_next;
  logic                 adv;
  logic                 emit;
  logic [7:0]           emit_byte;
  logic                 emit_end;
  logic [7:0]           hdr_byte;

  // output register can take a byte when empty or being drained
  assign adv = !out_valid || out_ready;

  always_comb begin
    unique case (step)
      3'd1:    hdr_byte = cur.frame_length[15:8];
      3'd2:    hdr_byte = cur.frame_length[7:0];
      3'd3:    hdr_byte = cur.heartbeat;
      3'd4:    hdr_byte = cfg.system_id;
      3'd5:    hdr_byte = cfg.component_id;
      3'd6:    hdr_byte = cur.msg_id;
      default: hdr_byte = cur.msg_id;
    endcase
  end

  always_comb begin
    state_next = state;
    cur_next   = cur;
    step_next  = step;
    crc_next   = crc;
    q_pop      = 1'b0;
    emit       = 1'b0;
    emit_byte  = 8'h00;
    emit_end   = 1'b0;
    unique case (state)
      cpf_pkg::ST_CMD: begin
        if (adv && !q_empty) begin
          q_pop    = 1'b1;
          emit     = 1'b1;
          cur_next = q_cmd;
          if (q_cmd.op == cpf_pkg::OP_START) begin
            emit_byte  = cfg.start_marker;
            crc_next   = cpf_pkg::CRC_SEED;
            step_next  = 3'd1;
            state_next = cpf_pkg::ST_HDR;
          end else begin
            emit_byte = q_cmd.payload_byte;
            crc_next  = cpf_pkg::crc_fold(crc, q_cmd.payload_byte);
            if (q_cmd.last) begin
              state_next = cpf_pkg::ST_CRC_LO;
            end
          end
        end
      end
      cpf_pkg::ST_HDR: begin
        if (adv) begin
          emit      = 1'b1;
          emit_byte = hdr_byte;
          crc_next  = cpf_pkg::crc_fold(crc, hdr_byte);
          step_next = step + 3'd1;
          if (step == 3'(cpf_pkg::HDR_BYTES - 1)) begin
            state_next = cur.last ? cpf_pkg::ST_CRC_LO : cpf_pkg::ST_CMD;
          end
        end
      end
      cpf_pkg::ST_CRC_LO: begin
        if (adv) begin
          emit       = 1'b1;
          emit_byte  = crc[7:0];
          state_next = cpf_pkg::ST_CRC_HI;
        end
      end
      cpf_pkg::ST_CRC_HI: begin
        if (adv) begin
          emit       = 1'b1;
          emit_byte  = crc[15:8];
          emit_end   = 1'b1;
          state_next = cpf_pkg::ST_CMD;
        end
      end
      default: state_next = cpf_pkg::ST_CMD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cpf_pkg::ST_CMD;
      crc       <= cpf_pkg::CRC_SEED;
      step      <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      crc   <= crc_next;
      step  <= step_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
    if (emit) begin
      out_byte  <= emit_byte;
      frame_end <= emit_end;
    end
  end

endmodule

>>> design/crc16_packet_framer.sv
// Channel | Signals                                              | Dir | Handshake
// input   | kind frame_length heartbeat msg_id payload_byte      | in  | in_valid/in_ready
// output  | out_byte frame_end                                   | out | out_valid/out_ready
// config  | cfg_index cfg_data                                   | in  | cfg_we, no wait
//
// Payload items stream through at one item per cycle unless the output stalls
// or header/CRC bytes go out; each byte passes the queue and output register,
// and the last one of a frame adds two CRC bytes after it. A start item gives
// seven header bytes, nine with CRC for a zero length frame; the back end's byte sequencer sets that figure.
// The classify stage keeps accepting into a small queue while the header goes
// out, so in_ready drops only when the queue is full.
// Reset is synchronous: queue empty, no frame open, output register empty.
// out_ready low holds the output byte; the back end stalls and the queue fills.
module crc16_packet_framer #(
  parameter int QUEUE_DEPTH = cpf_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [15:0] frame_length,
  input  logic [7:0]  heartbeat,
  input  logic [7:0]  msg_id,
  input  logic [7:0]  payload_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        frame_end,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  cpf_pkg::cfg_regs_t cfg;
  cpf_pkg::cmd_t      push_cmd;
  cpf_pkg::cmd_t      pop_cmd;
  logic               q_push;
  logic               q_pop;
  logic               q_full;
  logic               q_empty;

  // config registers; index 3 has no register and is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cpf_pkg::REG_START_MARKER: cfg.start_marker <= cfg_data;
        cpf_pkg::REG_SYSTEM_ID:    cfg.system_id    <= cfg_data;
        cpf_pkg::REG_COMPONENT_ID: cfg.component_id <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: tracks the open frame and tags each item (start / data, last)
  cpf_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .frame_length (frame_length),
    .heartbeat    (heartbeat),
    .msg_id       (msg_id),
    .payload_byte (payload_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (push_cmd)
  );

  cpf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  // back: header/payload/CRC byte sequencer with the running CRC
  cpf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_cmd     (pop_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .frame_end (frame_end)
  );

endmodule

>>> design/cpf_checker.sv
module cpf_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       frame_end
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(frame_end))
    else $error("output item changed while stalled");

  a_reset_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_reset_in: assert property (@(posedge clk) rst |=> in_ready)
    else $error("input not ready after reset");

  // a frame always carries a header between two checksum ends; this checks only that two ends are not back to back
  a_end_spacing: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && frame_end |=> !(out_valid && frame_end))
    else $error("two frame ends back to back");

endmodule

bind crc16_packet_framer cpf_checker u_cpf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_byte  (out_byte),
  .frame_end (frame_end)
);
